[rtl/nrb_pkg.sv]
package nrb_pkg;

  // Fixed-point format of radicand and root
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned INT_BITS   = 16;
  localparam int unsigned W          = INT_BITS + FRAC_BITS;
  localparam int unsigned DEG_W      = 4;
  localparam int unsigned MAX_DEGREE = 8;
  localparam int unsigned K_W        = $clog2(MAX_DEGREE);
  localparam int unsigned UPC_W      = 3;

  localparam logic [W-1:0] FIX_ONE = W'(1) << FRAC_BITS;

  typedef logic [UPC_W-1:0] upc_t;

  // Microprogram step addresses
  localparam upc_t STEP_IDLE  = 3'd0;
  localparam upc_t STEP_PROBE = 3'd1;
  localparam upc_t STEP_MUL   = 3'd2;
  localparam upc_t STEP_JUDGE = 3'd3;
  localparam upc_t STEP_EMIT  = 3'd4;
  localparam upc_t STEP_WRAP  = 3'd5;

  typedef enum logic [2:0] {
    COND_ALWAYS      = 3'd0,
    COND_IN_WAIT     = 3'd1,
    COND_SRCH_DONE   = 3'd2,
    COND_MUL_BUSY    = 3'd3,
    COND_OUT_BLOCKED = 3'd4
  } cond_e;

  typedef struct packed {
    logic  load;
    logic  probe;
    logic  mul;
    logic  judge;
    logic  emit;
    cond_e cond;
    upc_t  target;
  } ctrl_t;

  typedef struct packed {
    logic srch_done;
    logic mul_busy;
    logic out_blocked;
  } dp_stat_t;

  // Control store: jump to target when cond holds, else fall through
  function automatic ctrl_t nrb_rom(input upc_t addr);
    ctrl_t w;
    w = '{load: 1'b0, probe: 1'b0, mul: 1'b0, judge: 1'b0, emit: 1'b0,
          cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (addr)
      STEP_IDLE: begin
        w.load   = 1'b1;
        w.cond   = COND_IN_WAIT;
        w.target = STEP_IDLE;
      end
      STEP_PROBE: begin
        w.probe  = 1'b1;
        w.cond   = COND_SRCH_DONE;
        w.target = STEP_EMIT;
      end
      STEP_MUL: begin
        w.mul    = 1'b1;
        w.cond   = COND_MUL_BUSY;
        w.target = STEP_MUL;
      end
      STEP_JUDGE: begin
        w.judge  = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_PROBE;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BLOCKED;
        w.target = STEP_EMIT;
      end
      STEP_WRAP: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/nrb_in_if.sv]
interface nrb_in_if;
  import nrb_pkg::*;

  logic               valid;
  logic               ready;
  logic [W-1:0]       radicand;
  logic [DEG_W-1:0]   degree;

  modport source (output valid, output radicand, output degree, input ready);
  modport sink   (input valid, input radicand, input degree, output ready);
endinterface

[rtl/nrb_out_if.sv]
interface nrb_out_if;
  import nrb_pkg::*;

  logic         valid;
  logic         ready;
  logic [W-1:0] root_value;
  logic         exact;

  modport source (output valid, output root_value, output exact, input ready);
  modport sink   (input valid, input root_value, input exact, output ready);
endinterface

[rtl/nrb_sequencer.sv]
module nrb_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  nrb_pkg::dp_stat_t stat_i,
  output nrb_pkg::ctrl_t    ctrl_o,
  output logic              idle_o
);
  import nrb_pkg::*;

  upc_t  upc_q, upc_d;
  ctrl_t word;
  logic  take_jump;

  assign word = nrb_rom(upc_q);

  always_comb begin
    unique case (word.cond)
      COND_ALWAYS:      take_jump = 1'b1;
      COND_IN_WAIT:     take_jump = !in_valid_i;
      COND_SRCH_DONE:   take_jump = stat_i.srch_done;
      COND_MUL_BUSY:    take_jump = stat_i.mul_busy;
      COND_OUT_BLOCKED: take_jump = stat_i.out_blocked;
      default:          take_jump = 1'b1;
    endcase
  end

  always_comb begin
    upc_d = take_jump ? word.target : upc_q + upc_t'(1);
  end

  // Gate the datapath strobes with their conditions
  always_comb begin
    ctrl_o       = word;
    ctrl_o.load  = word.load && in_valid_i;
    ctrl_o.mul   = word.mul && stat_i.mul_busy;
    ctrl_o.emit  = word.emit && !stat_i.out_blocked;
  end

  assign idle_o = (upc_q == STEP_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

[rtl/nrb_datapath.sv]
module nrb_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nrb_pkg::ctrl_t             ctrl_i,
  input  logic [nrb_pkg::W-1:0]      radicand_i,
  input  logic [nrb_pkg::DEG_W-1:0]  degree_i,
  input  logic                       out_ready_i,
  output nrb_pkg::dp_stat_t          stat_o,
  output logic                       out_valid_o,
  output logic [nrb_pkg::W-1:0]      root_value_o,
  output logic                       exact_o
);
  import nrb_pkg::*;

  logic [W-1:0]   r_q, lo_q, hi_q, mid_q, p_q;
  logic [W-1:0]   span, mid, hi_init;
  logic [K_W-1:0] deg_m1_q, deg_m1, k_q;
  logic           ovf_q, eq_q, fits;
  logic [2*W-1:0] prod;
  logic           prod_ovf;
  logic           out_valid_q, exact_q;
  logic [W-1:0]   root_q;

  // Clamp degree to 1..MAX_DEGREE, kept as degree minus one
  always_comb begin
    if (degree_i == '0) begin
      deg_m1 = '0;
    end else if (degree_i > DEG_W'(MAX_DEGREE)) begin
      deg_m1 = K_W'(MAX_DEGREE - 1);
    end else begin
      deg_m1 = K_W'(degree_i - DEG_W'(1));
    end
  end

  assign hi_init = (radicand_i > FIX_ONE) ? radicand_i : FIX_ONE;

  // Upper middle of the interval
  assign span = hi_q - lo_q;
  assign mid  = lo_q + (span >> 1) + W'(span[0]);

  assign prod     = {{W{1'b0}}, p_q} * {{W{1'b0}}, mid_q};
  assign prod_ovf = |prod[2*W-1:W+FRAC_BITS];

  assign fits = !ovf_q && (p_q <= r_q);

  assign stat_o.srch_done   = !(lo_q < hi_q);
  assign stat_o.mul_busy    = (k_q != '0) && !ovf_q;
  assign stat_o.out_blocked = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      r_q      <= radicand_i;
      lo_q     <= '0;
      hi_q     <= hi_init;
      deg_m1_q <= deg_m1;
      eq_q     <= (radicand_i == '0);
    end
    if (ctrl_i.probe) begin
      mid_q <= mid;
      p_q   <= mid;
    end
    if (ctrl_i.mul) begin
      p_q <= prod[W+FRAC_BITS-1:FRAC_BITS];
    end
    if (ctrl_i.judge) begin
      if (fits) begin
        lo_q <= mid_q;
        eq_q <= (p_q == r_q);
      end else begin
        hi_q <= mid_q - W'(1);
      end
    end
    if (ctrl_i.emit) begin
      root_q  <= lo_q;
      exact_q <= eq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.probe) begin
        k_q   <= deg_m1_q;
        ovf_q <= 1'b0;
      end else if (ctrl_i.mul) begin
        k_q   <= k_q - K_W'(1);
        ovf_q <= prod_ovf;
      end
      // Hold the word until taken
      if (ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign root_value_o = root_q;
  assign exact_o      = exact_q;

endmodule

[rtl/nth_root_bisection.sv]
// Channel   Dir  Payload                         Handshake
// in_ch_i   in   radicand[31:0], degree[3:0]     valid/ready
// out_ch_o  out  root_value[31:0], exact         valid/ready
//
// One word at a time. A word takes up to 32 bisection probes, for a radicand
// near the top of the range; the single shared multiplier forms each
// power one factor a cycle, and a probe whose power overflows ends early.
// Reset (rst_ni low) returns the sequencer to idle and empties the output
// register. A stalled result sits in the output register while the next
// word is worked on; the sequencer waits at its emit step only when that
// word finishes first.
module nth_root_bisection (
  input logic     clk_i,
  input logic     rst_ni,
  nrb_in_if.sink  in_ch_i,
  nrb_out_if.source out_ch_o
);
  import nrb_pkg::*;

  ctrl_t    ctrl;
  dp_stat_t stat;
  logic     idle;

  nrb_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch_i.valid),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .idle_o     (idle)
  );

  nrb_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .radicand_i   (in_ch_i.radicand),
    .degree_i     (in_ch_i.degree),
    .out_ready_i  (out_ch_o.ready),
    .stat_o       (stat),
    .out_valid_o  (out_ch_o.valid),
    .root_value_o (out_ch_o.root_value),
    .exact_o      (out_ch_o.exact)
  );

  assign in_ch_i.ready = idle;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch_i.valid && in_ch_i.ready) |=> !in_ch_i.ready)
    else $error("input taken again while a word is in work");

  a_rose_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch_o.valid) |-> $past(ctrl.emit))
    else $error("result shown without an emit step");

  a_judge_after_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.judge |-> !stat.mul_busy)
    else $error("probe judged before its power was complete");

  a_no_mul_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle |-> !ctrl.mul && !ctrl.judge)
    else $error("datapath active while idle");

endmodule

[tb/nth_root_bisection_test.sv]
module nth_root_bisection_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nrb_pkg::*;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned WORD_LATENCY = 4 + 32 * (MAX_DEGREE + 2);
  localparam int unsigned SETTLE_CYCLES = WORD_LATENCY + 80;
  localparam longint unsigned CYCLE_LIMIT = 64'd6_000_000;

  typedef struct packed {
    logic [W-1:0] root;
    logic         exact;
  } root_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  nrb_in_if  in_ch ();
  nrb_out_if out_ch ();

  nth_root_bisection dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  root_res_t       expected_roots[$];
  bit              idling = 1'b1;
  int unsigned     mismatches;
  int unsigned     words_sent;
  int unsigned     words_checked;
  int unsigned     exact_seen;
  int unsigned     clamped_sent;
  int unsigned     stall_left;
  longint unsigned cycles;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Raise base to deg by truncated fixed-point products; 0 on overflow
  function automatic bit raise_fixed(input logic [W-1:0] base, input int unsigned deg,
                                     output logic [W-1:0] power);
    logic [2*W-1:0] prod;
    power = base;
    for (int unsigned i = 1; i < deg; i++) begin
      prod = {{W{1'b0}}, power} * {{W{1'b0}}, base};
      prod = prod >> FRAC_BITS;
      if (prod[2*W-1:W] != '0) return 1'b0;
      power = prod[W-1:0];
    end
    return 1'b1;
  endfunction

  function automatic root_res_t predict_root(input logic [W-1:0] rad,
                                             input logic [DEG_W-1:0] code);
    int unsigned  deg;
    logic [W-1:0] lo;
    logic [W-1:0] hi;
    logic [W-1:0] span;
    logic [W-1:0] mid;
    logic [W-1:0] pw;
    bit           fits;
    root_res_t    res;
    if (code == '0) deg = 1;
    else if (code > MAX_DEGREE) deg = MAX_DEGREE;
    else deg = code;
    lo = '0;
    hi = (rad > FIX_ONE) ? rad : FIX_ONE;
    // Probe the upper middle so the interval always shrinks
    while (lo < hi) begin
      span = hi - lo;
      mid  = lo + (span >> 1) + W'(span[0]);
      fits = raise_fixed(mid, deg, pw);
      if (fits && pw <= rad) lo = mid;
      else hi = mid - 1'b1;
    end
    fits      = raise_fixed(lo, deg, pw);
    res.root  = lo;
    res.exact = fits && (pw == rad);
    return res;
  endfunction

  // Entered and left at a falling edge; valid stays high for the next word
  task automatic send_word(input logic [W-1:0] rad, input logic [DEG_W-1:0] code);
    int unsigned gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.radicand <= rad;
    in_ch.degree   <= code;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_roots.push_back(predict_root(rad, code));
    words_sent++;
    if (code == '0 || code > MAX_DEGREE) clamped_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [DEG_W-1:0] random_degree();
    int unsigned pick;
    if ($urandom_range(0, 9) != 0) return DEG_W'($urandom_range(1, MAX_DEGREE));
    // Out-of-range codes: zero or above the largest degree
    pick = $urandom_range(0, 7);
    return (pick == 0) ? '0 : DEG_W'(pick + MAX_DEGREE);
  endfunction

  function automatic logic [W-1:0] random_radicand();
    case ($urandom_range(0, 3))
      0:       return W'($urandom());
      1:       return W'($urandom()) >> $urandom_range(0, W - 1);
      2:       return W'($urandom_range(0, FIX_ONE - 1));
      default: return {W{1'b1}} - W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_boundaries();
    send_word('0, DEG_W'(1));
    send_word('0, DEG_W'(MAX_DEGREE));
    send_word({W{1'b1}}, DEG_W'(1));
    send_word({W{1'b1}}, DEG_W'(2));
    send_word({W{1'b1}}, DEG_W'(MAX_DEGREE));
    send_word(W'(1), DEG_W'(2));
    send_word(W'(1), DEG_W'(MAX_DEGREE));
    send_word(FIX_ONE - 1'b1, DEG_W'(2));
    send_word(FIX_ONE, DEG_W'(7));
    send_word(W'(32'h0009_0000), DEG_W'(2));
  endtask

  // Every degree code, in range or not, on the radicand 2.0
  task automatic test_degree_range();
    for (int unsigned d = 0; d < (1 << DEG_W); d++)
      send_word(W'(32'h0002_0000), DEG_W'(d));
  endtask

  // Exact powers and their neighbours either side
  task automatic test_exact_powers(input int unsigned count);
    logic [W-1:0]     base;
    logic [W-1:0]     pw;
    logic [W-1:0]     rad;
    logic [DEG_W-1:0] code;
    int unsigned      deg;
    for (int unsigned n = 0; n < count; n++) begin
      code = DEG_W'($urandom_range(1, MAX_DEGREE));
      deg  = code;
      base = W'($urandom()) >> $urandom_range(0, W - 1);
      while (!raise_fixed(base, deg, pw)) base = base >> 1;
      case ($urandom_range(0, 2))
        0:       rad = (pw == '0) ? pw : pw - 1'b1;
        1:       rad = (pw == {W{1'b1}}) ? pw : pw + 1'b1;
        default: rad = pw;
      endcase
      send_word(rad, code);
    end
  endtask

  task automatic test_random(input int unsigned count, input bit with_idling);
    idling = with_idling;
    for (int unsigned n = 0; n < count; n++)
      send_word(random_radicand(), random_degree());
    idling = 1'b1;
  endtask

  // Receiver: while idling, random stalls, mostly short, now and then long
  always @(negedge clk_i) begin
    if (!idling) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    root_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_roots.size() == 0) begin
        $display("%0t: unexpected word: root %h exact %b", $time,
                 out_ch.root_value, out_ch.exact);
        mismatches++;
      end else begin
        want = expected_roots.pop_front();
        if (out_ch.root_value !== want.root) begin
          $display("%0t: word %0d root_value: expected %h, got %h", $time,
                   words_checked, want.root, out_ch.root_value);
          mismatches++;
        end
        if (out_ch.exact !== want.exact) begin
          $display("%0t: word %0d exact: expected %b, got %b", $time,
                   words_checked, want.exact, out_ch.exact);
          mismatches++;
        end
        if (want.exact) exact_seen++;
        words_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d words outstanding", $time, expected_roots.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.radicand = '0;
    in_ch.degree   = '0;
    out_ch.ready   = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_boundaries();
    test_degree_range();
    test_exact_powers(300);
    test_random(250, 1'b0);
    test_random(1300, 1'b1);

    in_ch.valid <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk_i);
    // Hold a while longer to catch stray words
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d words (%0d with out-of-range degree codes) in %0d cycles.",
             words_sent, clamped_sent, cycles);
    $display("Checked %0d results, %0d of them exact roots; %0d mismatches.",
             words_checked, exact_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
